// ----- sv/bhpq_pkg.sv -----
// Shared types and constants for the binary heap priority queue.
// Used by bhpq_ctrl, bhpq_dp and binary_heap_priority_queue_top; no dependencies.
package bhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int CNT_OUT_W    = 7;
  localparam int CAPACITY_DEF = 64;

  localparam logic signed [KEY_W-1:0] KEY_EMPTY = -32'sd1;
  localparam logic signed [KEY_W-1:0] KEY_ZERO  = 32'sd0;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [KEY_W-1:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    stat_t                   status;
    logic [CNT_OUT_W-1:0]    count_out;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_POP_KEY,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_KEY,
    WR_PARENT,
    WR_BEST
  } wr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic    push_start;
    logic    pop_start;
    logic    rej_empty;
    logic    rej_full;
    logic    take_root;
    logic    take_last;
    logic    up_move;
    logic    pick_left;
    logic    dn_move;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic at_root;
    logic left_ok;
    logic right_ok;
    logic up_beats;
    logic dn_move_ok;
    logic out_busy;
  } dp_stat_t;

  // true when a strictly beats b under the chosen order
  function automatic logic beats(input logic max_first,
                                 input logic signed [KEY_W-1:0] a,
                                 input logic signed [KEY_W-1:0] b);
    return max_first ? (a > b) : (a < b);
  endfunction

endpackage

// ----- sv/bhpq_ctrl.sv -----
// Sequencer for push, pop and sift steps of the heap.
// Depends on bhpq_pkg; drives bhpq_dp through bhpq_pkg::cmd_t.
module bhpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  bhpq_pkg::kind_t     in_kind,
  output logic                in_ready,
  input  bhpq_pkg::dp_stat_t  st,
  output bhpq_pkg::cmd_t      cmd
);

  bhpq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      bhpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == bhpq_pkg::KIND_POP) begin
            if (st.empty) begin
              cmd.rej_empty = 1'b1;
              state_nxt     = bhpq_pkg::S_FINISH;
            end else begin
              cmd.pop_start = 1'b1;
              state_nxt     = bhpq_pkg::S_POP_ROOT;
            end
          end else begin
            if (st.full) begin
              cmd.rej_full = 1'b1;
              state_nxt    = bhpq_pkg::S_FINISH;
            end else begin
              cmd.push_start = 1'b1;
              state_nxt      = bhpq_pkg::S_UP_CHK;
            end
          end
        end
      end
      bhpq_pkg::S_UP_CHK: begin
        if (st.at_root) begin
          cmd.wr_sel = bhpq_pkg::WR_KEY;
          state_nxt  = bhpq_pkg::S_FINISH;
        end else begin
          cmd.rd_sel = bhpq_pkg::RD_PARENT;
          state_nxt  = bhpq_pkg::S_UP_CMP;
        end
      end
      bhpq_pkg::S_UP_CMP: begin
        // move the parent down, or settle the new key here
        if (st.up_beats) begin
          cmd.wr_sel  = bhpq_pkg::WR_PARENT;
          cmd.up_move = 1'b1;
          state_nxt   = bhpq_pkg::S_UP_CHK;
        end else begin
          cmd.wr_sel = bhpq_pkg::WR_KEY;
          state_nxt  = bhpq_pkg::S_FINISH;
        end
      end
      bhpq_pkg::S_POP_ROOT: begin
        cmd.rd_sel = bhpq_pkg::RD_ROOT;
        state_nxt  = bhpq_pkg::S_POP_LAST;
      end
      bhpq_pkg::S_POP_LAST: begin
        cmd.take_root = 1'b1;
        cmd.rd_sel    = bhpq_pkg::RD_LAST;
        state_nxt     = bhpq_pkg::S_POP_KEY;
      end
      bhpq_pkg::S_POP_KEY: begin
        cmd.take_last = 1'b1;
        state_nxt     = st.empty ? bhpq_pkg::S_FINISH : bhpq_pkg::S_DN_RDL;
      end
      bhpq_pkg::S_DN_RDL: begin
        if (st.left_ok) begin
          cmd.rd_sel = bhpq_pkg::RD_LEFT;
          state_nxt  = bhpq_pkg::S_DN_RDR;
        end else begin
          cmd.wr_sel = bhpq_pkg::WR_KEY;
          state_nxt  = bhpq_pkg::S_FINISH;
        end
      end
      bhpq_pkg::S_DN_RDR: begin
        cmd.pick_left = 1'b1;
        if (st.right_ok) begin
          cmd.rd_sel = bhpq_pkg::RD_RIGHT;
        end
        state_nxt = bhpq_pkg::S_DN_CMP;
      end
      bhpq_pkg::S_DN_CMP: begin
        if (st.dn_move_ok) begin
          cmd.wr_sel  = bhpq_pkg::WR_BEST;
          cmd.dn_move = 1'b1;
          state_nxt   = bhpq_pkg::S_DN_RDL;
        end else begin
          cmd.wr_sel = bhpq_pkg::WR_KEY;
          state_nxt  = bhpq_pkg::S_FINISH;
        end
      end
      bhpq_pkg::S_FINISH: begin
        // hold until the output register is free
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = bhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/bhpq_dp.sv -----
// Heap datapath: key store, count, node index, comparators and output register.
// Depends on bhpq_pkg; commanded by bhpq_ctrl.
module bhpq_dp #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [bhpq_pkg::KEY_W-1:0] in_key,
  input  logic                              cfg_we,
  input  logic                              cfg_order,
  input  bhpq_pkg::cmd_t                    cmd,
  output bhpq_pkg::dp_stat_t                st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bhpq_pkg::out_item_t               out_item
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic signed [bhpq_pkg::KEY_W-1:0] mem [CAPACITY];

  logic                              order_r, order_nxt;
  logic [IW-1:0]                     cnt_r, cnt_nxt;
  logic [IW-1:0]                     node_r, node_nxt;
  logic [IW-1:0]                     best_idx_r, best_idx_nxt;
  logic signed [bhpq_pkg::KEY_W-1:0] best_val_r, best_val_nxt;
  logic signed [bhpq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [bhpq_pkg::KEY_W-1:0] result_r, result_nxt;
  bhpq_pkg::stat_t                   status_r, status_nxt;
  logic signed [bhpq_pkg::KEY_W-1:0] rdata_r;
  logic                              out_valid_r, out_valid_nxt;
  bhpq_pkg::out_item_t               out_r, out_nxt;

  logic [IW:0]                       left_idx, right_idx, cnt_ext;
  logic [IW-1:0]                     parent_idx;
  logic                              left_ok, right_ok, right_beat;
  logic [IW-1:0]                     fin_idx;
  logic signed [bhpq_pkg::KEY_W-1:0] fin_val;
  logic                              rd_en, wr_en;
  logic [AW-1:0]                     rd_addr, wr_addr;
  logic signed [bhpq_pkg::KEY_W-1:0] wr_data;

  assign left_idx   = {node_r, 1'b0};
  assign right_idx  = {node_r, 1'b1};
  assign cnt_ext    = {1'b0, cnt_r};
  assign parent_idx = node_r >> 1;
  assign left_ok    = (left_idx <= cnt_ext);
  assign right_ok   = (right_idx <= cnt_ext);

  // right child only counts against the better of node and left
  assign right_beat = right_ok && bhpq_pkg::beats(order_r, rdata_r, best_val_r);
  assign fin_idx    = right_beat ? right_idx[IW-1:0] : best_idx_r;
  assign fin_val    = right_beat ? rdata_r : best_val_r;

  always_comb begin
    st.empty      = (cnt_r == '0);
    st.full       = (cnt_r == IW'(CAPACITY));
    st.at_root    = (node_r == IW'(1));
    st.left_ok    = left_ok;
    st.right_ok   = right_ok;
    st.up_beats   = bhpq_pkg::beats(order_r, key_r, rdata_r);
    st.dn_move_ok = (fin_idx != node_r);
    st.out_busy   = out_valid_r && !out_ready;
  end

  // store port selection; indices are 1-based
  always_comb begin
    rd_en   = (cmd.rd_sel != bhpq_pkg::RD_NONE);
    rd_addr = '0;
    unique case (cmd.rd_sel)
      bhpq_pkg::RD_ROOT:   rd_addr = '0;
      bhpq_pkg::RD_LAST:   rd_addr = AW'(cnt_r - 1'b1);
      bhpq_pkg::RD_PARENT: rd_addr = AW'(parent_idx - 1'b1);
      bhpq_pkg::RD_LEFT:   rd_addr = AW'(left_idx - 1'b1);
      bhpq_pkg::RD_RIGHT:  rd_addr = AW'(right_idx - 1'b1);
      default:             rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = (cmd.wr_sel != bhpq_pkg::WR_NONE);
    wr_addr = AW'(node_r - 1'b1);
    wr_data = key_r;
    unique case (cmd.wr_sel)
      bhpq_pkg::WR_PARENT: wr_data = rdata_r;
      bhpq_pkg::WR_BEST:   wr_data = fin_val;
      default:             wr_data = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    order_nxt     = cfg_we ? cfg_order : order_r;
    cnt_nxt       = cnt_r;
    node_nxt      = node_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    key_nxt       = key_r;
    result_nxt    = result_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (cmd.push_start) begin
      cnt_nxt    = cnt_r + 1'b1;
      node_nxt   = cnt_r + 1'b1;
      key_nxt    = in_key;
      result_nxt = bhpq_pkg::KEY_ZERO;
      status_nxt = bhpq_pkg::STAT_DONE;
    end
    if (cmd.pop_start) begin
      status_nxt = bhpq_pkg::STAT_DONE;
    end
    if (cmd.rej_empty) begin
      result_nxt = bhpq_pkg::KEY_EMPTY;
      status_nxt = bhpq_pkg::STAT_EMPTY;
    end
    if (cmd.rej_full) begin
      result_nxt = bhpq_pkg::KEY_ZERO;
      status_nxt = bhpq_pkg::STAT_FULL;
    end
    if (cmd.take_root) begin
      result_nxt = rdata_r;
      cnt_nxt    = cnt_r - 1'b1;
    end
    if (cmd.take_last) begin
      key_nxt  = rdata_r;
      node_nxt = IW'(1);
    end
    if (cmd.up_move) begin
      node_nxt = parent_idx;
    end
    if (cmd.pick_left) begin
      if (bhpq_pkg::beats(order_r, rdata_r, key_r)) begin
        best_idx_nxt = left_idx[IW-1:0];
        best_val_nxt = rdata_r;
      end else begin
        best_idx_nxt = node_r;
        best_val_nxt = key_r;
      end
    end
    if (cmd.dn_move) begin
      node_nxt = fin_idx;
    end

    if (cmd.out_load) begin
      out_valid_nxt     = 1'b1;
      out_nxt.key_out   = result_r;
      out_nxt.status    = status_r;
      out_nxt.count_out = bhpq_pkg::CNT_OUT_W'(cnt_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      order_r     <= order_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    key_r      <= key_nxt;
    result_r   <= result_nxt;
    status_r   <= status_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- sv/binary_heap_priority_queue_top.sv -----
// Binary heap priority queue of signed 32-bit keys, min or max order.
// Channels: in_valid/in_ready carry a request (push key_in, or pop the root);
//   out_valid/out_ready return one result per request: popped key (-1 on an
//   empty pop, 0 for a push), status (done, pop on empty, push dropped when
//   full) and the key count afterwards. cfg_valid/cfg_ready write the order
//   bit (0 smallest at root, 1 largest); write it only while the block is idle.
// Flow: a push climbs the new key level by level towards the root; a pop takes
//   the root, moves the last key to the root and sinks it level by level, or ends
//   at once when that empties the heap; a rejected request goes straight to its
//   result. One request is in flight at a time; the key store, one read per
//   parent or child, sets the pace.
// Reset (rst_n low, synchronous) empties the heap and selects smallest first;
//   the key store itself is not cleared.
// Stall: a finished result waits in the output register; the next request is
//   taken and worked on, and holds at its end until the register drains.
// Depends on bhpq_pkg, bhpq_ctrl and bhpq_dp.
module binary_heap_priority_queue_top #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bhpq_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  bhpq_pkg::cmd_t     cmd;
  bhpq_pkg::dp_stat_t st;

  assign cfg_ready = 1'b1;

  bhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_item.kind),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_key    (in_item.key_in),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_order (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
